[hdl/oled_text_byte_sequencer_assert.svh]
// assertion macros for the oled text byte sequencer
`ifndef OLED_TEXT_BYTE_SEQUENCER_ASSERT_SVH
`define OLED_TEXT_BYTE_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define OTBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OTBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OTBS_ASSERT_NOW(label, clk, rst, ante, cons)
`define OTBS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/otbs_pkg.sv]
// shared types and constants of the oled text byte sequencer
`timescale 1ns / 1ps
package otbs_pkg;

  localparam int GLYPH_BYTES = 16;
  localparam int STEP_W      = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd21;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_CURSOR = 2'd1;
  localparam logic [1:0] OP_PUT    = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic              load;
    logic              set_cursor;
    logic              put;
    logic              issue;
    logic              done;
    logic [STEP_W-1:0] step;
  } otbs_cmd_t;

  typedef struct packed {
    logic can_issue;
  } otbs_status_t;

endpackage

[hdl/otbs_ctrl.sv]
// controller: accepts items and sequences the 22 bytes of a character
`timescale 1ns / 1ps
`include "oled_text_byte_sequencer_assert.svh"
module otbs_ctrl
  import otbs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic [1:0]   op,
  output logic         s_tready,
  input  otbs_status_t status,
  output otbs_cmd_t    cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.step       = step;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load       = (op == OP_LOAD);
          cmd.set_cursor = (op == OP_CURSOR);
          cmd.put        = (op == OP_PUT);
          if (op == OP_PUT) begin
            state_next = ST_RUN;
            step_next  = '0;
          end
        end
      end
      ST_RUN: begin
        if (status.can_issue) begin
          cmd.issue = 1'b1;
          if (step == LAST_STEP) begin
            cmd.done   = 1'b1;
            state_next = ST_IDLE;
            step_next  = '0;
          end else begin
            step_next = step + 5'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `OTBS_ASSERT_NOW(a_step_range, clk, rst, state == ST_RUN, step <= LAST_STEP)
  `OTBS_ASSERT_NEXT(a_hold_step, clk, rst, state == ST_RUN && !status.can_issue, $stable(step))
  `OTBS_ASSERT_NEXT(a_done_idle, clk, rst, cmd.done, state == ST_IDLE && step == 5'd0)

endmodule

[hdl/otbs_dp.sv]
// datapath: font memory, cursor, byte generation and output register
`timescale 1ns / 1ps
`include "oled_text_byte_sequencer_assert.svh"
module otbs_dp
  import otbs_pkg::*;
#(
  parameter int GLYPHS  = 95,
  parameter int COLUMNS = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  otbs_cmd_t    cmd,
  output otbs_status_t status,
  input  logic [10:0]  font_index,
  input  logic [7:0]   font_byte,
  input  logic [2:0]   page,
  input  logic [6:0]   column,
  input  logic [7:0]   character,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   spi_byte,
  output logic         is_data,
  output logic         last
);

  localparam int STORE  = GLYPHS * GLYPH_BYTES;
  localparam int ADDR_W = $clog2(STORE);
  localparam logic [4:0] HALF_STEPS = 5'd11;
  localparam logic [4:0] POS_PAGE   = 5'd0;
  localparam logic [4:0] POS_COL_LO = 5'd1;
  localparam logic [4:0] POS_COL_HI = 5'd2;
  localparam logic [4:0] POS_DATA0  = 5'd3;

  logic [7:0] font_mem [STORE];

  logic [2:0] cursor_page;
  logic [6:0] cursor_column;
  logic [7:0] glyph;
  logic [7:0] glyph_next;

  logic       s1_valid;
  logic [7:0] s1_cmd;
  logic       s1_is_data;
  logic       s1_last;
  logic [7:0] rd_data;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_is_data;
  logic       out_last;

  logic        out_free;
  logic        s1_move;
  logic        half;
  logic [4:0]  pos;
  logic [2:0]  row_lo;
  logic [3:0]  row;
  logic [2:0]  half_page;
  logic [7:0]  cmd_byte;
  logic [11:0] wr_ext;
  logic [11:0] rd_ext;
  logic [7:0]  col_sum;
  logic [7:0]  char_off;

  assign out_free         = !out_valid || m_tready;
  assign s1_move          = s1_valid && out_free;
  assign status.can_issue = !s1_valid || s1_move;

  // glyph select, out-of-range codes draw glyph 0
  assign char_off = character - 8'd32;
  always_comb begin
    glyph_next = '0;
    if (character >= 8'd32 && character <= 8'd126 && 32'(char_off) < GLYPHS) begin
      glyph_next = char_off;
    end
  end

  // step decode
  assign half      = (cmd.step >= HALF_STEPS);
  assign pos       = half ? (cmd.step - HALF_STEPS) : cmd.step;
  assign row_lo    = 3'(pos - POS_DATA0);
  assign row       = {half, row_lo};
  assign half_page = cursor_page + {2'b00, half};
  assign wr_ext    = {1'b0, font_index};
  assign rd_ext    = {glyph, row};

  always_comb begin
    case (pos)
      POS_PAGE:   cmd_byte = 8'hB0 + {5'b0, half_page};
      POS_COL_LO: cmd_byte = {4'b0, cursor_column[3:0]};
      POS_COL_HI: cmd_byte = 8'h10 + {5'b0, cursor_column[6:4]};
      default:    cmd_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && 32'(font_index) < STORE) begin
      font_mem[wr_ext[ADDR_W-1:0]] <= font_byte;
    end
    if (cmd.issue) begin
      rd_data <= font_mem[rd_ext[ADDR_W-1:0]];
    end
  end

  assign col_sum = {1'b0, cursor_column} + 8'd8;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_page   <= '0;
      cursor_column <= '0;
    end else if (cmd.set_cursor) begin
      cursor_page   <= page;
      cursor_column <= column;
    end else if (cmd.done) begin
      if (32'(col_sum) >= COLUMNS) begin
        cursor_column <= '0;
        cursor_page   <= cursor_page + 3'd2;
      end else begin
        cursor_column <= col_sum[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      glyph <= glyph_next;
    end
    if (cmd.issue) begin
      s1_cmd     <= cmd_byte;
      s1_is_data <= (pos >= POS_DATA0);
      s1_last    <= (cmd.step == LAST_STEP);
    end
    if (s1_move) begin
      out_byte    <= s1_is_data ? rd_data : s1_cmd;
      out_is_data <= s1_is_data;
      out_last    <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign spi_byte = out_byte;
  assign is_data  = out_is_data;
  assign last     = out_last;

  `OTBS_ASSERT_NEXT(a_issue_fills, clk, rst, cmd.issue, s1_valid)
  `OTBS_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !out_free, s1_valid && $stable(s1_cmd))
  `OTBS_ASSERT_NOW(a_last_is_data, clk, rst, out_valid && out_last, out_is_data)

endmodule

[hdl/oled_text_byte_sequencer.sv]
// Page-mode OLED text byte sequencer: characters in, controller command/data bytes out.
// Input channel s_*: s_tuser carries the op (load font byte, set cursor, put character),
// s_tdata the operands. An item is taken when s_tvalid and s_tready are both high.
// Output channel m_*: one byte per item, m_tuser high for display data, low for a
// command, m_tlast high on the final byte of a character.
// A put-character item gives 22 bytes: page, low column and high column commands
// then 8 glyph bytes, for the upper and then the lower page of the glyph.
// Load and set-cursor items give no bytes.
// After a character is taken it is sequenced with one issue per byte, one font
// memory read per issue through a single read port; each byte passes the read stage
// and then the output register.
// s_tready is low while a character is being sequenced.
// When m_tready is low with the output register full, that register holds, the read
// stage holds once it fills and the sequencer then stops issuing; nothing is dropped.
// Reset puts the cursor at page 0, column 0 and empties the pipeline; the font memory
// keeps its contents and must be loaded before use.
`timescale 1ns / 1ps
module oled_text_byte_sequencer
  import otbs_pkg::*;
#(
  parameter int GLYPHS  = 95,
  parameter int COLUMNS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // font_index[10:0], font_byte[18:11], page[21:19], column[28:22],
  // character[36:29], zero[39:37]
  input  logic [39:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // spi_byte[7:0]
  output logic [7:0]  m_tdata,
  // is_data[0]
  output logic        m_tuser,
  output logic        m_tlast
);

  otbs_cmd_t    cmd;
  otbs_status_t status;

  otbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  otbs_dp #(
    .GLYPHS  (GLYPHS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .font_index (s_tdata[10:0]),
    .font_byte  (s_tdata[18:11]),
    .page       (s_tdata[21:19]),
    .column     (s_tdata[28:22]),
    .character  (s_tdata[36:29]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .spi_byte   (m_tdata),
    .is_data    (m_tuser),
    .last       (m_tlast)
  );

endmodule

[verif/oled_text_byte_sequencer_tb.sv]
// self-checking testbench for the oled text byte sequencer
`timescale 1ns / 1ps
module oled_text_byte_sequencer_tb;
  import otbs_pkg::*;

  localparam int NUM_GLYPHS  = 95;
  localparam int NUM_COLUMNS = 128;
  localparam int STORE_SIZE  = NUM_GLYPHS * GLYPH_BYTES;
  localparam int RAND_ITEMS  = 345;
  localparam int HOLD_CYCLES = 250;
  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [7:0] PAGE_CMD   = 8'hB0;
  localparam logic [7:0] COL_HI_CMD = 8'h10;

  typedef struct packed {
    logic [7:0] spi;
    logic       is_data;
    logic       fin;
  } disp_byte_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] idx;
    logic [7:0]  fbyte;
    logic [2:0]  pg;
    logic [6:0]  col;
    logic [7:0]  ch;
    logic        typed;
    logic [23:0] head;
  } stim_row_t;

  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_LOAD,   11'd0,    8'h00, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd1,    8'hFF, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd2,    8'h01, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd3,    8'h80, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd4,    8'h55, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd5,    8'hAA, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd6,    8'h0F, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd7,    8'hF0, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd8,    8'h7E, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd9,    8'h81, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd10,   8'h3C, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd11,   8'hC3, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd12,   8'hFE, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd13,   8'h7F, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd14,   8'h18, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd15,   8'hE7, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    // control code, cursor at reset position
    '{OP_PUT,    11'd0,    8'h00, 3'd0, 7'd0,   8'd0,   1'b1, 24'hB0_00_10},
    '{OP_PUT,    11'd0,    8'h00, 3'd0, 7'd0,   8'd255, 1'b1, 24'hB0_08_10},
    '{OP_CURSOR, 11'd0,    8'h00, 3'd7, 7'd127, 8'd0,   1'b0, 24'h0},
    // last page and column, lower page wraps, cursor wraps two pages down
    '{OP_PUT,    11'd0,    8'h00, 3'd0, 7'd0,   8'd32,  1'b1, 24'hB7_0F_17},
    '{OP_PUT,    11'd0,    8'h00, 3'd0, 7'd0,   8'd127, 1'b1, 24'hB1_00_10},
    '{OP_PUT,    11'd0,    8'h00, 3'd0, 7'd0,   8'd31,  1'b1, 24'hB1_08_10},
    // loads past the font store are dropped
    '{OP_LOAD,   11'd2047, 8'hFF, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_LOAD,   11'd1520, 8'hAA, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0},
    '{OP_NONE,   11'd0,    8'h00, 3'd0, 7'd0,   8'd0,   1'b0, 24'h0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  logic [7:0]  font_mem [STORE_SIZE];
  bit          font_set [STORE_SIZE];
  logic [2:0]  cur_page;
  logic [6:0]  cur_col;
  disp_byte_t  pending_bytes [$];
  int          ready_glyphs [$];

  bit steady;
  bit hold_req;
  int n_bad;
  int n_checked;
  int n_chars;
  int n_items;

  oled_text_byte_sequencer #(
    .GLYPHS (NUM_GLYPHS),
    .COLUMNS(NUM_COLUMNS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [39:0] pack_fields(logic [10:0] idx, logic [7:0] fb,
                                              logic [2:0] pg, logic [6:0] col,
                                              logic [7:0] ch);
    return {3'b000, ch, col, pg, fb, idx};
  endfunction

  function automatic int glyph_of(logic [7:0] ch);
    if (ch >= 8'd32 && ch <= 8'd126 && int'(ch) - 32 < NUM_GLYPHS) begin
      return int'(ch) - 32;
    end
    return 0;
  endfunction

  function automatic bit glyph_loaded(int g);
    for (int r = 0; r < GLYPH_BYTES; r++) begin
      if (!font_set[g * GLYPH_BYTES + r]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic expect_byte(logic [7:0] b, logic d, logic l);
    pending_bytes.push_back({b, d, l});
  endtask

  // expected byte stream of one item, cursor and font store kept alongside
  task automatic predict_bytes(logic [1:0] op, logic [39:0] d, logic typed,
                               logic [23:0] head);
    logic [10:0] idx;
    logic [2:0]  pg;
    logic [7:0]  cmd [3];
    int          g;
    idx = d[10:0];
    case (op)
      OP_LOAD: begin
        if (int'(idx) < STORE_SIZE) begin
          font_mem[idx] = d[18:11];
          font_set[idx] = 1'b1;
        end
      end
      OP_CURSOR: begin
        cur_page = d[21:19];
        cur_col  = d[28:22];
      end
      OP_PUT: begin
        g = glyph_of(d[36:29]);
        n_chars++;
        for (int h = 0; h < 2; h++) begin
          pg = cur_page + 3'(h);
          cmd[0] = PAGE_CMD + {5'd0, pg};
          cmd[1] = {4'd0, cur_col[3:0]};
          cmd[2] = COL_HI_CMD + {5'd0, cur_col[6:4]};
          if (typed && h == 0) begin
            cmd[0] = head[23:16];
            cmd[1] = head[15:8];
            cmd[2] = head[7:0];
          end
          for (int k = 0; k < 3; k++) begin
            expect_byte(cmd[k], 1'b0, 1'b0);
          end
          for (int r = 0; r < 8; r++) begin
            expect_byte(font_mem[g * GLYPH_BYTES + h * 8 + r], 1'b1, h == 1 && r == 7);
          end
        end
        if (int'(cur_col) + 8 >= NUM_COLUMNS) begin
          cur_col  = 7'd0;
          cur_page = cur_page + 3'd2;
        end else begin
          cur_col = cur_col + 7'd8;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] op, logic [39:0] d, logic typed, logic [23:0] head);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    predict_bytes(op, d, typed, head);
  endtask

  task automatic load_glyph(int g);
    for (int r = 0; r < GLYPH_BYTES; r++) begin
      send_item(OP_LOAD, pack_fields(11'(g * GLYPH_BYTES + r), 8'($urandom_range(255)),
                3'd0, 7'd0, 8'd0), 1'b0, 24'h0);
    end
    if (!(g inside {ready_glyphs})) begin
      ready_glyphs.push_back(g);
    end
  endtask

  task automatic put_random;
    logic [7:0] ch;
    if ($urandom_range(1)) begin
      ch = 8'($urandom_range(255));
      while (!glyph_loaded(glyph_of(ch))) begin
        ch = 8'($urandom_range(255));
      end
    end else begin
      ch = 8'(32 + ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
    end
    send_item(OP_PUT, pack_fields(11'd0, 8'd0, 3'd0, 7'd0, ch), 1'b0, 24'h0);
  endtask

  task automatic note_mismatch(string what, disp_byte_t want);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%s: expected %02h data %0b last %0b, got %02h data %0b last %0b",
               what, want.spi, want.is_data, want.fin, m_tdata, m_tuser, m_tlast);
    end
  endtask

  // output side: random ready, one long hold on request
  initial begin : drain
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 33);
        @(negedge clk);
      end
    end
  end

  initial begin : out_monitor
    disp_byte_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_bytes.size() == 0) begin
          note_mismatch("unexpected item", '0);
        end else begin
          want = pending_bytes.pop_front();
          n_checked++;
          if (m_tdata !== want.spi || m_tuser !== want.is_data || m_tlast !== want.fin) begin
            note_mismatch($sformatf("mismatch on item %0d", n_checked), want);
          end
        end
      end
    end
  end

  initial begin
    int  pick;
    int  force_puts;
    bit  held;
    bit  paused;
    logic [10:0] idx;
    stim_row_t row;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = OP_LOAD;
    steady     = 1'b0;
    hold_req   = 1'b0;
    cur_page   = 3'd0;
    cur_col    = 7'd0;
    n_bad      = 0;
    n_checked  = 0;
    n_chars    = 0;
    n_items    = 0;
    force_puts = 0;
    held       = 1'b0;
    paused     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      send_item(row.op, pack_fields(row.idx, row.fbyte, row.pg, row.col, row.ch),
                row.typed, row.head);
    end
    ready_glyphs.push_back(0);

    // the last glyph reaches the top of the font store
    load_glyph(NUM_GLYPHS - 1);
    send_item(OP_PUT, pack_fields(11'd0, 8'd0, 3'd0, 7'd0, 8'd126), 1'b0, 24'h0);
    n_items = 17;

    while (n_items < RAND_ITEMS) begin
      steady = n_items >= 120 && n_items < 190;
      if (n_items >= 240 && !held) begin
        held       = 1'b1;
        hold_req   = 1'b1;
        force_puts = 6;
      end
      if (n_items >= 300 && !paused) begin
        paused = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (force_puts > 0) begin
        pick = 99;
        force_puts--;
      end
      if (pick < 10) begin
        load_glyph($urandom_range(NUM_GLYPHS - 1));
        n_items += GLYPH_BYTES;
      end else if (pick < 20) begin
        idx = 11'($urandom_range(2047));
        send_item(OP_LOAD, pack_fields(idx, 8'($urandom_range(255)), 3'd0, 7'd0, 8'd0),
                  1'b0, 24'h0);
        n_items++;
      end else if (pick < 36) begin
        send_item(OP_CURSOR, pack_fields(11'd0, 8'd0, 3'($urandom_range(7)),
                  7'($urandom_range(1) ? $urandom_range(127, 112) : $urandom_range(127)),
                  8'd0), 1'b0, 24'h0);
        n_items++;
      end else if (pick < 40) begin
        send_item(OP_NONE, pack_fields(11'($urandom_range(2047)), 8'($urandom_range(255)),
                  3'($urandom_range(7)), 7'($urandom_range(127)), 8'($urandom_range(255))),
                  1'b0, 24'h0);
        n_items++;
      end else begin
        put_random();
        n_items++;
      end
    end
    steady = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d items in, %0d characters drawn, %0d glyphs loaded",
             n_items + DIR_ROWS, n_chars, ready_glyphs.size());
    $display("%0d bytes checked, %0d mismatches", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[oled_text_byte_sequencer.f]
+incdir+hdl
hdl/otbs_pkg.sv
hdl/otbs_ctrl.sv
hdl/otbs_dp.sv
hdl/oled_text_byte_sequencer.sv
verif/oled_text_byte_sequencer_tb.sv
